>>> design/pidaw_pkg.sv
// Shared widths, register map codes and stage payload types of the PID controller.
package pidaw_pkg;

  // Field widths
  localparam int DATA_W      = 16;
  localparam int ERROR_W     = 17;
  localparam int DERIV_W     = 18;
  localparam int INTEGRAL_W  = 32;
  localparam int GAIN_W      = 32;
  localparam int WINDUP_W    = 17;
  localparam int LIMIT_W     = 31;
  localparam int DRIVE_W     = 32;

  // Product widths of the three gain multiplies
  localparam int PROD_P_W    = GAIN_W + ERROR_W;
  localparam int PROD_I_W    = GAIN_W + INTEGRAL_W;
  localparam int PROD_D_W    = GAIN_W + DERIV_W;
  localparam int SUM_W       = 64;

  // Default fraction bits of the Q gains
  localparam int GAIN_FRACTION_BITS_DEF = 16;

  // Configuration port
  localparam int APB_ADDR_W  = 5;
  localparam int APB_DATA_W  = 32;
  localparam int REG_IDX_W   = 3;

  localparam logic [REG_IDX_W-1:0] REG_GAIN_P         = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_GAIN_I         = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_GAIN_D         = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_WINDUP_RANGE   = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_INTEGRAL_LIMIT = 3'd4;

  localparam logic [WINDUP_W-1:0] WINDUP_RESET = {WINDUP_W{1'b1}};

  // Input command codes
  localparam logic CMD_STEP  = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;

  // Error, integral and derivative of one step (two's complement bits)
  typedef struct packed {
    logic [ERROR_W-1:0]    error;
    logic [INTEGRAL_W-1:0] integral;
    logic [DERIV_W-1:0]    derivative;
  } terms_t;

  // Registered gain products of one step
  typedef struct packed {
    logic [PROD_P_W-1:0] prod_p;
    logic [PROD_I_W-1:0] prod_i;
    logic [PROD_D_W-1:0] prod_d;
  } products_t;

endpackage

>>> design/pid_antiwindup_controller.sv
// Top level of the PID controller with integral clamp anti-windup.
//
//  Channel   Direction  Beat contents
//  --------  ---------  ------------------------------------------------------------
//  s_axis    in         tuser: command; tdata: target, measured
//  m_axis    out        tdata: drive, error_out, integral_out, derivative_out
//  apb       in         gain_p, gain_i, gain_d, windup_range, integral_limit
//
// One beat is accepted per cycle while the output is not stalled; after its beat is accepted,
// a result passes the input register, update stage, multiply stage and output register.
// The error and integral state loop closes inside the update stage.
// Reset clears the stage valid flags, the controller state, the gains and the integral
// limit, and sets the windup range to all ones. A stalled output holds the pipeline only where the stage ahead is full.
module pid_antiwindup_controller #(
  parameter int GAIN_FRACTION_BITS = pidaw_pkg::GAIN_FRACTION_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  // Input stream
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [31:0]                         s_tdata,   // [15:0] target, [31:16] measured
  input  logic                                s_tuser,   // [0] command
  // Output stream
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [103:0]                        m_tdata,   // [31:0] drive, [48:32] error_out,
                                                         // [80:49] integral_out,
                                                         // [98:81] derivative_out, rest zero
  // Configuration port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [pidaw_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [pidaw_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [pidaw_pkg::APB_DATA_W-1:0]    prdata,
  output logic                                pready
);
  import pidaw_pkg::*;

  logic [GAIN_W-1:0]     gain_p;
  logic [GAIN_W-1:0]     gain_i;
  logic [GAIN_W-1:0]     gain_d;
  logic [WINDUP_W-1:0]   windup_range;
  logic [LIMIT_W-1:0]    integral_limit;

  logic [REG_IDX_W-1:0]  reg_idx;
  logic                  cfg_write;

  logic                  in_valid;
  logic                  mul_valid;
  logic                  sum_valid;
  logic                  out_valid;
  logic                  in_command;
  logic [DATA_W-1:0]     in_target;
  logic [DATA_W-1:0]     in_measured;

  logic                  out_ready;
  logic                  sum_ready;
  logic                  mul_ready;
  logic                  load_mul;
  logic                  load_sum;
  logic                  load_out;
  logic                  in_accept;

  terms_t                terms_mul;
  terms_t                terms_sum;
  terms_t                terms_out;
  products_t             products;
  logic [DRIVE_W-1:0]    drive;

  // Configuration registers.
  assign pready    = 1'b1;
  assign reg_idx   = paddr[APB_ADDR_W-1:2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_p         <= '0;
      gain_i         <= '0;
      gain_d         <= '0;
      windup_range   <= WINDUP_RESET;
      integral_limit <= '0;
    end else if (cfg_write) begin
      case (reg_idx)
        REG_GAIN_P:         gain_p         <= pwdata;
        REG_GAIN_I:         gain_i         <= pwdata;
        REG_GAIN_D:         gain_d         <= pwdata;
        REG_WINDUP_RANGE:   windup_range   <= pwdata[WINDUP_W-1:0];
        REG_INTEGRAL_LIMIT: integral_limit <= pwdata[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    case (reg_idx)
      REG_GAIN_P:         prdata = gain_p;
      REG_GAIN_I:         prdata = gain_i;
      REG_GAIN_D:         prdata = gain_d;
      REG_WINDUP_RANGE:   prdata = {{(APB_DATA_W-WINDUP_W){1'b0}}, windup_range};
      REG_INTEGRAL_LIMIT: prdata = {{(APB_DATA_W-LIMIT_W){1'b0}}, integral_limit};
      default:            prdata = '0;
    endcase
  end

  // Stage handshakes: each stage moves when the one ahead is empty or moving.
  assign out_ready = !out_valid || m_tready;
  assign sum_ready = !sum_valid || out_ready;
  assign mul_ready = !mul_valid || sum_ready;
  assign s_tready  = !in_valid || mul_ready;
  assign in_accept = s_tvalid && s_tready;
  assign load_mul  = in_valid && mul_ready;
  assign load_sum  = mul_valid && sum_ready;
  assign load_out  = sum_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      mul_valid <= 1'b0;
      sum_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      in_valid  <= in_accept || (in_valid && !mul_ready);
      mul_valid <= load_mul || (mul_valid && !sum_ready);
      sum_valid <= load_sum || (sum_valid && !out_ready);
      out_valid <= load_out || (out_valid && !m_tready);
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      in_command  <= s_tuser;
      in_target   <= s_tdata[DATA_W-1:0];
      in_measured <= s_tdata[2*DATA_W-1:DATA_W];
    end
  end

  pidaw_update u_update (
    .clk            (clk),
    .rst            (rst),
    .load           (load_mul),
    .command        (in_command),
    .target         (in_target),
    .measured       (in_measured),
    .windup_range   (windup_range),
    .integral_limit (integral_limit),
    .terms          (terms_mul)
  );

  pidaw_mult u_mult (
    .clk       (clk),
    .load      (load_sum),
    .gain_p    (gain_p),
    .gain_i    (gain_i),
    .gain_d    (gain_d),
    .terms_in  (terms_mul),
    .terms_out (terms_sum),
    .products  (products)
  );

  pidaw_drive #(
    .GAIN_FRACTION_BITS (GAIN_FRACTION_BITS)
  ) u_drive (
    .clk       (clk),
    .load      (load_out),
    .terms_in  (terms_sum),
    .products  (products),
    .drive     (drive),
    .terms_out (terms_out)
  );

  // Output beat packing.
  assign m_tvalid = out_valid;
  assign m_tdata  = {5'b00000, terms_out.derivative, terms_out.integral,
                     terms_out.error, drive};

endmodule

>>> design/pidaw_update.sv
// Error, derivative and anti-windup integral update with the stored controller state.
module pidaw_update (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                load,
  input  logic                                command,
  input  logic [pidaw_pkg::DATA_W-1:0]        target,
  input  logic [pidaw_pkg::DATA_W-1:0]        measured,
  input  logic [pidaw_pkg::WINDUP_W-1:0]      windup_range,
  input  logic [pidaw_pkg::LIMIT_W-1:0]       integral_limit,
  output pidaw_pkg::terms_t                   terms
);
  import pidaw_pkg::*;

  logic signed [ERROR_W-1:0]    previous_error;
  logic signed [INTEGRAL_W-1:0] integral_sum;
  terms_t                       terms_next;

  // Step arithmetic for the item held in the input register.
  always_comb begin
    logic signed [ERROR_W-1:0]      err;
    logic signed [DERIV_W-1:0]      der;
    logic signed [INTEGRAL_W:0]     sum_wide;
    logic signed [INTEGRAL_W-1:0]   acc;
    logic signed [INTEGRAL_W:0]     acc_wide;
    logic signed [INTEGRAL_W:0]     lim_wide;
    logic [ERROR_W-1:0]             mag;
    logic                           sign_change;

    err = $signed({target[DATA_W-1], target}) - $signed({measured[DATA_W-1], measured});
    der = $signed({err[ERROR_W-1], err}) - $signed({previous_error[ERROR_W-1], previous_error});

    // Accumulate with saturation at the 32-bit limits.
    sum_wide = $signed({integral_sum[INTEGRAL_W-1], integral_sum})
             + $signed({{(INTEGRAL_W+1-ERROR_W){err[ERROR_W-1]}}, err});
    if (sum_wide[INTEGRAL_W] != sum_wide[INTEGRAL_W-1]) begin
      acc = sum_wide[INTEGRAL_W] ? {1'b1, {(INTEGRAL_W-1){1'b0}}}
                                 : {1'b0, {(INTEGRAL_W-1){1'b1}}};
    end else begin
      acc = sum_wide[INTEGRAL_W-1:0];
    end

    // Zero the integral when the error is out of the windup range.
    mag = err[ERROR_W-1] ? (~err + 1'b1) : err;
    if (mag > windup_range) begin
      acc = '0;
    end

    // Clamp to the integral limit; zero disables the clamp.
    acc_wide = {acc[INTEGRAL_W-1], acc};
    lim_wide = {2'b00, integral_limit};
    if (integral_limit != '0) begin
      if (acc_wide > lim_wide) begin
        acc = lim_wide[INTEGRAL_W-1:0];
      end else if (acc_wide < -lim_wide) begin
        acc = -lim_wide[INTEGRAL_W-1:0];
      end
    end

    // Zero the integral when the error sign changes, zero counting as its own sign.
    sign_change = ((previous_error == '0) != (err == '0))
               || ((err != '0) && (previous_error[ERROR_W-1] != err[ERROR_W-1]));
    if (sign_change) begin
      acc = '0;
    end

    if (command == CMD_CLEAR) begin
      terms_next = '0;
    end else begin
      terms_next.error      = err;
      terms_next.integral   = acc;
      terms_next.derivative = der;
    end
  end

  // Stored state advances once per item as it leaves the input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      previous_error <= '0;
      integral_sum   <= '0;
    end else if (load) begin
      previous_error <= $signed(terms_next.error);
      integral_sum   <= $signed(terms_next.integral);
    end
  end

  // Stage register toward the multipliers.
  always_ff @(posedge clk) begin
    if (load) begin
      terms <= terms_next;
    end
  end

endmodule

>>> design/pidaw_mult.sv
// Three parallel signed gain multiplies with a product register.
module pidaw_mult (
  input  logic                            clk,
  input  logic                            load,
  input  logic [pidaw_pkg::GAIN_W-1:0]    gain_p,
  input  logic [pidaw_pkg::GAIN_W-1:0]    gain_i,
  input  logic [pidaw_pkg::GAIN_W-1:0]    gain_d,
  input  pidaw_pkg::terms_t               terms_in,
  output pidaw_pkg::terms_t               terms_out,
  output pidaw_pkg::products_t            products
);
  import pidaw_pkg::*;

  logic signed [PROD_P_W-1:0] prod_p;
  logic signed [PROD_I_W-1:0] prod_i;
  logic signed [PROD_D_W-1:0] prod_d;

  // Signed products at full width.
  assign prod_p = $signed(gain_p) * $signed(terms_in.error);
  assign prod_i = $signed(gain_i) * $signed(terms_in.integral);
  assign prod_d = $signed(gain_d) * $signed(terms_in.derivative);

  // Register the products and carry the step terms alongside.
  always_ff @(posedge clk) begin
    if (load) begin
      products.prod_p <= prod_p;
      products.prod_i <= prod_i;
      products.prod_d <= prod_d;
      terms_out       <= terms_in;
    end
  end

endmodule

>>> design/pidaw_drive.sv
// Product sum, fraction shift, saturation and the output register.
module pidaw_drive #(
  parameter int GAIN_FRACTION_BITS = pidaw_pkg::GAIN_FRACTION_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             load,
  input  pidaw_pkg::terms_t                terms_in,
  input  pidaw_pkg::products_t             products,
  output logic [pidaw_pkg::DRIVE_W-1:0]    drive,
  output pidaw_pkg::terms_t                terms_out
);
  import pidaw_pkg::*;

  logic signed [SUM_W-1:0] sum;
  logic signed [SUM_W-1:0] scaled;
  logic [DRIVE_W-1:0]      drive_next;

  // Sum of the sign-extended products, then an arithmetic shift down.
  assign sum = $signed({{(SUM_W-PROD_P_W){products.prod_p[PROD_P_W-1]}}, products.prod_p})
             + $signed(products.prod_i)
             + $signed({{(SUM_W-PROD_D_W){products.prod_d[PROD_D_W-1]}}, products.prod_d});
  assign scaled = sum >>> GAIN_FRACTION_BITS;

  // Saturate to the signed drive width.
  always_comb begin
    if (scaled[SUM_W-1:DRIVE_W-1] == {(SUM_W-DRIVE_W+1){scaled[DRIVE_W-1]}}) begin
      drive_next = scaled[DRIVE_W-1:0];
    end else if (scaled[SUM_W-1]) begin
      drive_next = {1'b1, {(DRIVE_W-1){1'b0}}};
    end else begin
      drive_next = {1'b0, {(DRIVE_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      drive     <= drive_next;
      terms_out <= terms_in;
    end
  end

endmodule

>>> test/tb.sv
// Self-checking testbench for the PID controller with integral clamp anti-windup.
`timescale 1ns / 1ps

module tb;
  import pidaw_pkg::*;

  localparam int RUN_LIMIT   = 3_000_000;
  localparam int DRAIN_WAIT  = 8;
  localparam int LONG_STEPS  = 40;
  localparam int RAND_PHASES = 6;
  localparam int PHASE_STEPS = 275;

  // One input beat: command plus target and measured position
  typedef struct {
    logic        cmd;
    logic [15:0] target;
    logic [15:0] measured;
  } pid_step_t;

  // One output beat split into its fields
  typedef struct {
    logic [31:0] drive;
    logic [16:0] error;
    logic [31:0] integral;
    logic [17:0] deriv;
  } pid_result_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [31:0]  s_tdata = '0;   // [15:0] target, [31:16] measured
  logic         s_tuser = 1'b0; // [0] command
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [103:0] m_tdata;        // [31:0] drive, [48:32] error, [80:49] integral,
                                // [98:81] derivative
  logic         psel = 1'b0;
  logic         penable = 1'b0;
  logic         pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic         pready;

  pid_step_t   pending_steps[$];
  pid_result_t expected_results[$];
  pid_step_t   cur_step;
  int          errors = 0;
  int          cycle_count = 0;
  int          burst_left = 1;
  int          gap_left = 0;
  int          hold_cnt = 0;

  // Controller copy: settings and state
  longint kp = 0, ki = 0, kd = 0;
  longint windup_mag = 131071;
  longint integ_clamp = 0;
  longint last_error = 0;
  longint integ_acc = 0;

  pid_antiwindup_controller u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  function automatic longint clip32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic int sign_of(input longint v);
    if (v > 0) return 1;
    if (v < 0) return -1;
    return 0;
  endfunction

  // Advances the controller copy by one beat and returns the result it gives.
  function automatic pid_result_t pid_predict(input pid_step_t st);
    pid_result_t r;
    longint e, d, acc, mag, sum;
    r = '{default: '0};
    if (st.cmd == CMD_CLEAR) begin
      last_error = 0;
      integ_acc = 0;
      return r;
    end
    e = longint'($signed(st.target)) - longint'($signed(st.measured));
    d = e - last_error;
    acc = clip32(integ_acc + e);
    mag = (e < 0) ? -e : e;
    // Large error discards the integral.
    if (mag > windup_mag) acc = 0;
    // Magnitude clamp, disabled when the limit is zero.
    if (integ_clamp != 0) begin
      if (acc > integ_clamp) acc = integ_clamp;
      else if (acc < -integ_clamp) acc = -integ_clamp;
    end
    // A change of error sign restarts the integral.
    if (sign_of(last_error) != sign_of(e)) acc = 0;
    last_error = e;
    integ_acc = acc;
    sum = kp * e + ki * acc + kd * d;
    sum = clip32(sum >>> GAIN_FRACTION_BITS_DEF);
    r.drive = sum[31:0];
    r.error = e[16:0];
    r.integral = acc[31:0];
    r.deriv = d[17:0];
    return r;
  endfunction

  task automatic flag_mismatch(input string what, input longint want, input longint got);
    errors++;
    $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
  endtask

  // APB write: setup cycle, access cycle, then the local copy follows.
  task automatic reg_write(input logic [REG_IDX_W-1:0] idx, input logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_GAIN_P:         kp = longint'($signed(val));
      REG_GAIN_I:         ki = longint'($signed(val));
      REG_GAIN_D:         kd = longint'($signed(val));
      REG_WINDUP_RANGE:   windup_mag = longint'(val[WINDUP_W-1:0]);
      REG_INTEGRAL_LIMIT: integ_clamp = longint'(val[LIMIT_W-1:0]);
      default: ;
    endcase
  endtask

  // Queues one beat; target and measured keep their low 16 bits.
  task automatic push_step(input logic cmd, input int t, input int m);
    pid_step_t st;
    st.cmd = cmd;
    st.target = 16'(t);
    st.measured = 16'(m);
    pending_steps.push_back(st);
  endtask

  // Queues a control step with the given error and a random operating point.
  task automatic push_error(input int e);
    int lo, hi, m;
    lo = (e >= 0) ? -32768 : -32768 - e;
    hi = (e >= 0) ? 32767 - e : 32767;
    m = lo + int'($urandom_range(0, hi - lo));
    push_step(CMD_STEP, m + e, m);
  endtask

  // Waits until every queued beat has left and every result has arrived.
  task automatic settle();
    do @(negedge clk);
    while (pending_steps.size() != 0 || s_tvalid || expected_results.size() != 0);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  // Picks a random setting for every register, extremes included.
  task automatic shuffle_settings();
    logic [REG_IDX_W-1:0] gain_regs[3];
    logic [31:0] v;
    gain_regs = '{REG_GAIN_P, REG_GAIN_I, REG_GAIN_D};
    foreach (gain_regs[k]) begin
      case ($urandom_range(0, 6))
        0: v = $urandom;
        1: v = 32'h7FFF_FFFF;
        2: v = 32'h8000_0000;
        3: v = '0;
        default: v = $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
      endcase
      reg_write(gain_regs[k], v);
    end
    case ($urandom_range(0, 3))
      0: v = '0;
      1: v = 32'h0001_FFFF;
      2: v = $urandom_range(1, 2000);
      default: v = $urandom_range(0, 131071);
    endcase
    // Upper bits beyond the register width must be dropped.
    reg_write(REG_WINDUP_RANGE, v | ($urandom & 32'hFFFE_0000));
    case ($urandom_range(0, 4))
      0: v = '0;
      1: v = 32'd1;
      2: v = $urandom_range(1, 100000);
      3: v = 32'h7FFF_FFFF;
      default: v = $urandom & 32'h7FFF_FFFF;
    endcase
    reg_write(REG_INTEGRAL_LIMIT, v | ($urandom & 32'h8000_0000));
  endtask

  // Driver: feeds queued beats in bursts with random gaps.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      burst_left = 1;
      gap_left = 0;
    end else begin
      if (s_tvalid && s_tready) expected_results.push_back(pid_predict(cur_step));
      if (!s_tvalid || s_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_tvalid <= 1'b0;
        end else if (pending_steps.size() != 0) begin
          cur_step = pending_steps.pop_front();
          s_tvalid <= 1'b1;
          s_tuser <= cur_step.cmd;
          s_tdata <= {cur_step.measured, cur_step.target};
          burst_left--;
          if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 400)
                                                     : $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
          end
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result beat and stalls the output on its own pattern.
  always @(posedge clk) begin : monitor
    pid_result_t want;
    if (rst) begin
      m_tready <= 1'b0;
      hold_cnt = 2;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_results.size() == 0) begin
          errors++;
          $display("%0t ns: unexpected result, expected none, actual drive %0d",
                   $time, $signed(m_tdata[31:0]));
        end else begin
          want = expected_results.pop_front();
          if (m_tdata[31:0] !== want.drive)
            flag_mismatch("drive", $signed(want.drive), $signed(m_tdata[31:0]));
          if (m_tdata[48:32] !== want.error)
            flag_mismatch("error", $signed(want.error), $signed(m_tdata[48:32]));
          if (m_tdata[80:49] !== want.integral)
            flag_mismatch("integral", $signed(want.integral), $signed(m_tdata[80:49]));
          if (m_tdata[98:81] !== want.deriv)
            flag_mismatch("derivative", $signed(want.deriv), $signed(m_tdata[98:81]));
          if (m_tdata[103:99] !== 5'b0)
            flag_mismatch("padding", 0, m_tdata[103:99]);
        end
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
      end else if (m_tready) begin
        m_tready <= 1'b0;
        hold_cnt = $urandom_range(0, 3);
      end else begin
        m_tready <= 1'b1;
        hold_cnt = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(0, 15);
      end
    end
  end

  // Watchdog against a hung handshake.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == RUN_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Stimulus sequence.
  initial begin : stimulus
    int left, run, pol, mag, pick;
    bit wide;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: zero gains, widest windup range, no clamp.
    push_step(CMD_STEP, 1234, -20);
    push_step(CMD_STEP, 32767, -32768);
    push_step(CMD_CLEAR, 16'hFFFF, 16'hFFFF);
    settle();

    // Directed walk through the anti-windup rules.
    reg_write(REG_GAIN_P, 32'h0001_0000);
    reg_write(REG_GAIN_I, 32'h0000_4000);
    reg_write(REG_GAIN_D, 32'hFFFF_8000);
    reg_write(REG_WINDUP_RANGE, 32'd1000);
    reg_write(REG_INTEGRAL_LIMIT, 32'd3000);
    push_step(CMD_STEP, 5, 5);             // zero error
    push_step(CMD_STEP, 100, 0);           // sign leaves zero, integral restarts
    push_step(CMD_STEP, 300, 100);
    push_step(CMD_STEP, 0, -700);
    push_step(CMD_STEP, 1500, 0);          // above the windup range
    push_step(CMD_STEP, 1000, 0);          // exactly at the windup range
    push_step(CMD_STEP, 900, -100);
    push_step(CMD_STEP, 999, 0);
    push_step(CMD_STEP, 2, 0);             // positive clamp
    push_step(CMD_STEP, -50, 0);           // sign change
    push_step(CMD_STEP, -1000, 0);
    push_step(CMD_STEP, -1000, 0);
    push_step(CMD_STEP, -32768, -31768);
    push_step(CMD_STEP, -1000, 0);         // negative clamp
    push_step(CMD_STEP, 0, 0);             // back to zero error
    push_step(CMD_CLEAR, 16'hFFFF, 16'hFFFF);
    push_step(CMD_STEP, 32767, -32768);    // largest positive error
    push_step(CMD_STEP, -32768, 32767);    // largest negative error and derivative
    push_step(CMD_STEP, -32768, 0);        // measured zero, target is the error
    settle();

    // Largest gains drive the output into both saturation limits.
    reg_write(REG_GAIN_P, 32'h7FFF_FFFF);
    reg_write(REG_GAIN_I, 32'h7FFF_FFFF);
    reg_write(REG_GAIN_D, 32'h7FFF_FFFF);
    reg_write(REG_WINDUP_RANGE, 32'hFFFF_FFFF);
    reg_write(REG_INTEGRAL_LIMIT, 32'h7FFF_FFFF);
    push_step(CMD_STEP, 32767, -32768);
    push_step(CMD_STEP, 32767, -32768);
    push_step(CMD_STEP, -32768, 32767);
    settle();
    reg_write(REG_GAIN_P, 32'h8000_0000);
    reg_write(REG_GAIN_I, 32'h8000_0000);
    reg_write(REG_GAIN_D, 32'h8000_0000);
    reg_write(REG_WINDUP_RANGE, 32'd0);
    reg_write(REG_INTEGRAL_LIMIT, 32'd1);
    push_step(CMD_STEP, 32767, -32768);
    push_step(CMD_STEP, 1, 0);
    push_step(CMD_STEP, 0, 0);
    settle();

    // Long same-sign runs at the largest error build the integral with no clamp.
    reg_write(REG_GAIN_P, 32'd0);
    reg_write(REG_GAIN_I, 32'd1);
    reg_write(REG_GAIN_D, 32'd0);
    reg_write(REG_WINDUP_RANGE, 32'h0001_FFFF);
    reg_write(REG_INTEGRAL_LIMIT, 32'd0);
    push_step(CMD_CLEAR, 0, 0);
    for (int k = 0; k < LONG_STEPS; k++) push_step(CMD_STEP, 32767, -32768);
    push_step(CMD_CLEAR, 0, 0);
    for (int k = 0; k < LONG_STEPS; k++) push_step(CMD_STEP, -32768, 32767);
    push_step(CMD_CLEAR, 0, 0);
    settle();

    // Random phases: mostly same-sign error runs, some clears and noise.
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      shuffle_settings();
      left = PHASE_STEPS;
      while (left > 0) begin
        run = $urandom_range(1, 40);
        pick = $urandom_range(0, 9);
        pol = (pick == 0) ? 0 : ((pick < 5) ? 1 : -1);
        wide = ($urandom_range(0, 3) == 0);
        for (int k = 0; k < run && left > 0; k++) begin
          pick = $urandom_range(0, 19);
          if (pick == 0) begin
            push_step(CMD_CLEAR, int'($urandom), int'($urandom));
          end else if (pick == 1) begin
            push_step(CMD_STEP, int'($urandom), int'($urandom));
          end else begin
            mag = wide ? $urandom_range(0, 65535)
                       : $urandom_range(0, $urandom_range(1, 1500));
            push_error(pol * mag);
          end
          left--;
        end
      end
      settle();
    end

    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

>>> pid_antiwindup_controller.f
design/pidaw_pkg.sv
design/pidaw_update.sv
design/pidaw_mult.sv
design/pidaw_drive.sv
design/pid_antiwindup_controller.sv
test/tb.sv
